[design/iafs_pkg.sv]
// Package for the index allocator with a LIFO free stack.
// Holds pool sizes, field widths, opcode and status codes.
// No dependencies; used by index_allocator_free_stack.
package iafs_pkg;

  localparam int MAX_SLOTS = 4096;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int CAP_W   = 13;
  localparam int DEPTH_W = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W  = $clog2(MAX_SLOTS);
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  localparam logic [APB_AW-1:0] ADDR_CAPACITY = APB_AW'(0);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);
  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'((MAX_SLOTS < 4096) ? MAX_SLOTS : 4096);
  localparam logic [DEPTH_W-1:0] STACK_FULL = DEPTH_W'(MAX_SLOTS);

  typedef enum logic [1:0] {
    OP_ALLOC_ONE = 2'd0,
    OP_ALLOC_RUN = 2'd1,
    OP_FREE_ONE  = 2'd2,
    OP_FREE_RUN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

endpackage

[design/iafs_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No package dependency; used for the free stack.
module iafs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/index_allocator_free_stack.sv]
// Slot index allocator: bump pointer with a LIFO free stack in a RAM.
// Depends on iafs_pkg and iafs_ram.
//
//   channel   handshake                       payload
//   request   start / busy                    in_opcode, in_slot_index, in_run_count
//   result    out_strobe (one cycle)          out_granted_index, out_status
//   config    psel penable pwrite pready      paddr, pwdata, prdata (capacity)
//
// Bump allocations, single frees and rejected requests: result in the cycle after
// the request, busy stays low, so a request may follow every cycle.
// Allocation from the free stack: busy during S_POP (RAM read), result registered there.
// Batch free: one push per cycle through the stack RAM write port, zero skipped;
// busy over run_count indices or until overflow, result in the cycle after the last.
// Reset is synchronous; the stack RAM is not cleared, so no clearing pass.
// The result receiver cannot stall; each result is shown for one cycle.
module index_allocator_free_stack
  import iafs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [CNT_W-1:0]  in_run_count,
  output logic              out_strobe,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic [1:0]        out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_BFREE
  } state_t;

  state_t             state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [CAP_W-1:0]   bump_r, bump_nxt;
  logic [CAP_W-1:0]   capacity_r;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [IDX_W-1:0]   out_granted_r, out_granted_nxt;
  status_t            out_status_r, out_status_nxt;

  logic [CAP_W-1:0]   cap_eff;
  logic [CAP_W:0]     run_end;
  logic [DEPTH_W-1:0] depth_m1;
  logic               stack_full;
  logic               cfg_write;
  op_t                op;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]   ram_rdata;

  iafs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign op         = op_t'(in_opcode);
  assign cap_eff    = (capacity_r > CAP_LIMIT) ? CAP_LIMIT : capacity_r;
  assign run_end    = {1'b0, bump_r} + {1'b0, in_run_count};
  assign depth_m1   = depth_r - DEPTH_W'(1);
  assign stack_full = (depth_r >= STACK_FULL);
  assign ram_waddr  = depth_r[ADDR_W-1:0];
  assign ram_raddr  = depth_m1[ADDR_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    depth_nxt       = depth_r;
    bump_nxt        = bump_r;
    cur_nxt         = cur_r;
    rem_nxt         = rem_r;
    out_strobe_nxt  = 1'b0;
    out_granted_nxt = '0;
    out_status_nxt  = ST_OK;
    ram_we          = 1'b0;
    ram_wdata       = in_slot_index;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_ALLOC_ONE: begin
              if (depth_r != '0) begin
                depth_nxt = depth_m1;
                state_nxt = S_POP;
              end else if (bump_r >= cap_eff) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_NO_SPACE;
              end else begin
                out_strobe_nxt  = 1'b1;
                out_granted_nxt = bump_r[IDX_W-1:0];
                bump_nxt        = bump_r + CAP_W'(1);
              end
            end
            OP_ALLOC_RUN: begin
              out_strobe_nxt = 1'b1;
              if (in_run_count == '0) begin
                out_status_nxt = ST_IGNORED;
              end else if (run_end > {1'b0, cap_eff}) begin
                out_status_nxt = ST_NO_SPACE;
              end else begin
                out_granted_nxt = bump_r[IDX_W-1:0];
                bump_nxt        = run_end[CAP_W-1:0];
              end
            end
            OP_FREE_ONE: begin
              out_strobe_nxt = 1'b1;
              if (in_slot_index == '0) begin
                out_status_nxt = ST_IGNORED;
              end else if (stack_full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end
            OP_FREE_RUN: begin
              if (in_run_count == '0) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_IGNORED;
              end else begin
                cur_nxt   = in_slot_index;
                rem_nxt   = in_run_count;
                state_nxt = S_BFREE;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_IGNORED;
            end
          endcase
        end
      end
      S_POP: begin
        out_strobe_nxt  = 1'b1;
        out_granted_nxt = ram_rdata;
        state_nxt       = S_IDLE;
      end
      S_BFREE: begin
        ram_wdata = cur_r;
        cur_nxt   = cur_r + IDX_W'(1);
        rem_nxt   = rem_r - CNT_W'(1);
        if (cur_r != '0 && stack_full) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_OVERFLOW;
          state_nxt      = S_IDLE;
        end else begin
          if (cur_r != '0) begin
            ram_we    = 1'b1;
            depth_nxt = depth_r + DEPTH_W'(1);
          end
          if (rem_r == CNT_W'(1)) begin
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      bump_r       <= CAP_W'(1);
      capacity_r   <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      bump_r       <= bump_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_write) begin
        capacity_r <= pwdata[CAP_W-1:0];
      end
    end
    cur_r         <= cur_nxt;
    rem_r         <= rem_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_granted_index = out_granted_r;
  assign out_status        = out_status_r;
  assign prdata            = (paddr == ADDR_CAPACITY) ?
                             {{(APB_DW-CAP_W){1'b0}}, capacity_r} : '0;
  assign pready            = 1'b1;

endmodule
